FILE: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int OPC_W   = 2;
   localparam int KEY_W   = 32;
   localparam int IDX_W   = 6;
   localparam int ST_W    = 3;
   localparam int COUNT_W = 7;

   // request tdata: key, index, padded to whole bytes
   localparam int REQ_TDATA_W = 40;
   // response tdata: removed_key, min_key, entry_count, padded to whole bytes
   localparam int RSP_TDATA_W = 72;

   typedef enum logic [OPC_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_DECREASE = 2'd2,
      OP_DELETE   = 2'd3
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_BADIDX     = 3'd3,
      ST_NOTSMALLER = 3'd4
   } status_type;

   typedef struct packed {
      status_type               status;
      logic signed [KEY_W-1:0]  removed_key;
      logic signed [KEY_W-1:0]  min_key;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_type;

endpackage

FILE: design/min_heap_priority_queue_core.sv
// Each request walks the heap one level at a time, with a read and then a
// compare-and-write per level; delete walks up to the root and then down.
// Throughput: one request at a time, bounded by the read-compare-write loop
// on the single heap memory.
// Reset: synchronous, clears the key count; heap memory is not cleared.
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap priority queue over signed 32-bit keys, stream interface.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] key, [37:32] index, [39:38] zero
   input  logic [mhpq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] opcode
   input  logic [mhpq_pkg::OPC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] removed_key, [63:32] min_key, [70:64] entry_count, [71] zero
   output logic [mhpq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [2:0] status
   output logic [mhpq_pkg::ST_W-1:0]           rsp_tuser
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                    rd_en, wr_en, done, out_free;
   logic [AW-1:0]           rd_addr_a, rd_addr_b, wr_addr;
   logic signed [KEY_W-1:0] rd_data_a, rd_data_b, wr_data;
   rsp_type                 rsp;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic [ST_W-1:0]         rsp_user_ff;

   mhpq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   mhpq_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (opcode_type'(req_tuser)),
      .req_key    (req_tdata[KEY_W-1:0]),
      .req_index  (req_tdata[KEY_W+IDX_W-1:KEY_W]),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .done       (done),
      .rsp        (rsp),
      .rd_en      (rd_en),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // hold the result until taken; the engine may start the next request
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done) begin
         rsp_data_ff <= RSP_TDATA_W'({rsp.entry_count, rsp.min_key, rsp.removed_key});
         rsp_user_ff <= rsp.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

FILE: design/mhpq_store.sv
// ----------------------------------------------------------------------------
// mhpq_store
// Heap key array: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_store #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(CAPACITY)-1:0]         rd_addr_a,
   input  logic [$clog2(CAPACITY)-1:0]         rd_addr_b,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rd_data_a,
   output logic signed [mhpq_pkg::KEY_W-1:0]   rd_data_b,
   input  logic                                wr_en,
   input  logic [$clog2(CAPACITY)-1:0]         wr_addr,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   wr_data
);
   import mhpq_pkg::*;

   logic signed [KEY_W-1:0] mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: design/mhpq_engine.sv
// ----------------------------------------------------------------------------
// mhpq_engine
// Sequencer for insert, extract, decrease and delete on the heap array.
// ----------------------------------------------------------------------------
module mhpq_engine #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  mhpq_pkg::opcode_type                req_opcode,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
   input  logic [mhpq_pkg::IDX_W-1:0]          req_index,
   output logic                                req_ready,
   input  logic                                out_free,
   output logic                                done,
   output mhpq_pkg::rsp_type                   rsp,
   output logic                                rd_en,
   output logic [$clog2(CAPACITY)-1:0]         rd_addr_a,
   output logic [$clog2(CAPACITY)-1:0]         rd_addr_b,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   rd_data_a,
   input  logic signed [mhpq_pkg::KEY_W-1:0]   rd_data_b,
   output logic                                wr_en,
   output logic [$clog2(CAPACITY)-1:0]         wr_addr,
   output logic signed [mhpq_pkg::KEY_W-1:0]   wr_data
);
   import mhpq_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CHW  = AW + 2;
   localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEC_RD,
      S_DEC_CHK,
      S_DEL_RD,
      S_DEL_CAP,
      S_SH_ISSUE,
      S_SH_WR,
      S_EX_RD,
      S_EX_CAP,
      S_UP_ISSUE,
      S_UP_CMP,
      S_DN_ISSUE,
      S_DN_CMP,
      S_FIN_RD,
      S_OUT
   } state_type;

   state_type               state_ff, state_in;
   opcode_type              op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic signed [KEY_W-1:0] removed_ff, removed_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           count_ff, count_in;
   status_type              status_ff, status_in;

   logic [AW-1:0]           parent;
   logic [CHW-1:0]          left_w, right_w, count_ch;
   logic                    left_ok, right_ok, take_l, take_r, bad_idx;
   logic signed [KEY_W-1:0] best_val;

   assign parent   = (pos_ff - AW'(1)) >> 1;
   assign left_w   = {1'b0, pos_ff, 1'b1};
   assign right_w  = {1'b0, pos_ff, 1'b0} + CHW'(2);
   assign count_ch = CHW'(count_ff);
   assign left_ok  = left_w < count_ch;
   assign right_ok = right_w < count_ch;
   assign take_l   = left_ok && (rd_data_a < key_ff);
   assign best_val = take_l ? rd_data_a : key_ff;
   assign take_r   = right_ok && (rd_data_b < best_val);
   assign bad_idx  = CMPW'(req_index) >= CMPW'(count_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign done      = (state_ff == S_OUT) && out_free;

   always_comb begin
      rsp.status      = status_ff;
      rsp.removed_key = removed_ff;
      rsp.min_key     = (count_ff != '0) ? rd_data_a : '0;
      rsp.entry_count = COUNT_W'(count_ff);
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      removed_in = removed_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      rd_addr_a  = pos_ff;
      rd_addr_b  = pos_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = key_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               key_in     = req_key;
               removed_in = '0;
               status_in  = ST_OK;
               state_in   = S_FIN_RD;
               case (req_opcode)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        pos_in   = AW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_ISSUE;
                     end
                  end
                  OP_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_EX_RD;
                     end
                  end
                  OP_DECREASE: begin
                     if (bad_idx) begin
                        status_in = ST_BADIDX;
                     end else begin
                        pos_in   = AW'(req_index);
                        state_in = S_DEC_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (bad_idx) begin
                        status_in = ST_BADIDX;
                     end else begin
                        pos_in   = AW'(req_index);
                        state_in = S_DEL_RD;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_DEC_RD: begin
            rd_en    = 1'b1;
            state_in = S_DEC_CHK;
         end
         S_DEC_CHK: begin
            if (key_ff > rd_data_a) begin
               status_in = ST_NOTSMALLER;
               state_in  = S_FIN_RD;
            end else begin
               state_in = S_UP_ISSUE;
            end
         end
         S_DEL_RD: begin
            rd_en    = 1'b1;
            state_in = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            removed_in = rd_data_a;
            state_in   = S_SH_ISSUE;
         end
         // pull each ancestor down one level; the root is then taken out
         S_SH_ISSUE: begin
            if (pos_ff == '0) begin
               state_in = S_EX_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = parent;
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data_a;
            pos_in   = parent;
            state_in = S_SH_ISSUE;
         end
         S_EX_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = '0;
            rd_addr_b = AW'(count_ff - CW'(1));
            count_in  = count_ff - CW'(1);
            state_in  = S_EX_CAP;
         end
         S_EX_CAP: begin
            if (op_ff == OP_EXTRACT) begin
               removed_in = rd_data_a;
            end
            key_in   = rd_data_b;
            pos_in   = '0;
            state_in = S_DN_ISSUE;
         end
         // hole moves up while the parent is strictly larger
         S_UP_ISSUE: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_FIN_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a > key_ff) begin
               wr_data  = rd_data_a;
               pos_in   = parent;
               state_in = S_UP_ISSUE;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_DN_ISSUE: begin
            rd_en     = 1'b1;
            rd_addr_a = AW'(left_w);
            rd_addr_b = AW'(right_w);
            state_in  = S_DN_CMP;
         end
         // left child wins a tie between the children
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data  = rd_data_b;
               pos_in   = AW'(right_w);
               state_in = S_DN_ISSUE;
            end else if (take_l) begin
               wr_data  = rd_data_a;
               pos_in   = AW'(left_w);
               state_in = S_DN_ISSUE;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_FIN_RD: begin
            rd_en     = 1'b1;
            rd_addr_a = '0;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      removed_ff <= removed_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min-heap priority queue core. A shadow heap
// predicts the response to every accepted request. Responses are compared
// field by field in order. Stimulus is a directed opening, then random fill,
// mixed and drain phases. Both stream sides idle at random, and one long
// receiver hold-off backs the core up.
// ----------------------------------------------------------------------------
module tb_top;
   import mhpq_pkg::*;

   localparam int CAP          = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_TAIL   = 60;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 48;
   localparam int MIXED_ITEMS  = 80;
   localparam int IDX_MAX      = (1 << IDX_W) - 1;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef enum int {
      MODE_FILL,
      MODE_MIXED,
      MODE_DRAIN
   } mix_mode_type;

   class heap_scoreboard;
      logic signed [KEY_W-1:0] keys [CAP];
      int unsigned             held;
      rsp_type                 pending_rsp [$];
      int                      errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function logic signed [KEY_W-1:0] peek(int unsigned pos);
         return keys[pos];
      endfunction

      function int unsigned pending();
         return pending_rsp.size();
      endfunction

      function void swap_keys(int unsigned a, int unsigned b);
         logic signed [KEY_W-1:0] t;
         t       = keys[a];
         keys[a] = keys[b];
         keys[b] = t;
      endfunction

      // move an entry towards the root; to_root ignores the ordering
      function void rise(int unsigned pos, bit to_root);
         int unsigned up;
         while (pos != 0) begin
            up = (pos - 1) / 2;
            if (!to_root && !(keys[pos] < keys[up])) break;
            swap_keys(pos, up);
            pos = up;
         end
      endfunction

      // take the root, refill from the last entry and sink it; left child wins ties
      function logic signed [KEY_W-1:0] pop_root();
         logic signed [KEY_W-1:0] top;
         int unsigned             pos;
         int unsigned             l;
         int unsigned             r;
         int unsigned             best;
         top = keys[0];
         held--;
         keys[0] = keys[held];
         pos = 0;
         while (pos < held) begin
            l    = 2 * pos + 1;
            r    = l + 1;
            best = pos;
            if (l < held && keys[l] < keys[best]) best = l;
            if (r < held && keys[r] < keys[best]) best = r;
            if (best == pos) break;
            swap_keys(pos, best);
            pos = best;
         end
         return top;
      endfunction

      function void note_request(opcode_type op, logic signed [KEY_W-1:0] key,
                                 logic [IDX_W-1:0] idx);
         rsp_type r;
         r.status      = ST_OK;
         r.removed_key = '0;
         case (op)
            OP_INSERT: begin
               if (held >= CAP) begin
                  r.status = ST_FULL;
               end else begin
                  keys[held] = key;
                  held++;
                  rise(held - 1, 1'b0);
               end
            end
            OP_EXTRACT: begin
               if (held == 0) r.status = ST_EMPTY;
               else r.removed_key = pop_root();
            end
            OP_DECREASE: begin
               if (idx >= held) begin
                  r.status = ST_BADIDX;
               end else if (key > keys[idx]) begin
                  r.status = ST_NOTSMALLER;
               end else begin
                  keys[idx] = key;
                  rise(idx, 1'b0);
               end
            end
            default: begin
               if (idx >= held) begin
                  r.status = ST_BADIDX;
               end else begin
                  r.removed_key = keys[idx];
                  rise(idx, 1'b1);
                  void'(pop_root());
               end
            end
         endcase
         r.min_key     = (held > 0) ? keys[0] : '0;
         r.entry_count = COUNT_W'(held);
         pending_rsp = {pending_rsp, r};
      endfunction

      function void check_response(logic [ST_W-1:0] status, logic [RSP_TDATA_W-1:0] data);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (data[KEY_W-1:0] !== want.removed_key) begin
            $error("removed_key: expected %0d, actual %0d", want.removed_key,
                   $signed(data[KEY_W-1:0]));
            errors++;
         end
         if (data[2*KEY_W-1:KEY_W] !== want.min_key) begin
            $error("min_key: expected %0d, actual %0d", want.min_key,
                   $signed(data[2*KEY_W-1:KEY_W]));
            errors++;
         end
         if (data[2*KEY_W+COUNT_W-1:2*KEY_W] !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   data[2*KEY_W+COUNT_W-1:2*KEY_W]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OPC_W-1:0]       req_tuser  = OP_INSERT;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ST_W-1:0]        rsp_tuser;

   heap_scoreboard heap_sb;
   int             accepted  = 0;
   bit             hold_due  = 1'b0;
   bit             quiet     = 1'b0;

   min_heap_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   task automatic send_request(input opcode_type op, input logic signed [KEY_W-1:0] key,
                               input logic [IDX_W-1:0] idx);
      int gap;
      if (!quiet && ((accepted / 32) % 3 != 2) && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W-KEY_W-IDX_W){1'b0}}, idx, key};
      do @(posedge clock); while (!req_tready);
      heap_sb.note_request(op, key, idx);
      accepted++;
      if (accepted == HOLD_AT) hold_due = 1'b1;
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2, 3, 4: return KEY_W'($signed($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // mostly a key at or below the current one, sometimes anything
   function automatic logic signed [KEY_W-1:0] lower_key(logic signed [KEY_W-1:0] cur);
      longint v;
      case ($urandom_range(0, 3))
         0: return cur;
         1: return KEY_MIN;
         2: begin
            v = longint'(cur) - longint'($urandom_range(0, 1000));
            return (v < longint'(KEY_MIN)) ? KEY_MIN : KEY_W'(v);
         end
         default: return pick_key();
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      if (heap_sb.held > 0 && $urandom_range(0, 7) != 0)
         return IDX_W'($urandom_range(0, heap_sb.held - 1));
      return IDX_W'($urandom_range(0, IDX_MAX));
   endfunction

   task automatic random_request(input mix_mode_type mode);
      int                      r;
      opcode_type              op;
      logic [IDX_W-1:0]        idx;
      logic signed [KEY_W-1:0] key;
      r = $urandom_range(0, 19);
      case (mode)
         MODE_FILL:  op = (r < 18) ? OP_INSERT : ((r == 18) ? OP_DECREASE : OP_DELETE);
         MODE_DRAIN: op = (r < 15) ? OP_EXTRACT : ((r < 18) ? OP_DELETE : OP_INSERT);
         default: begin
            if (r < 7)       op = OP_INSERT;
            else if (r < 11) op = OP_EXTRACT;
            else if (r < 16) op = OP_DECREASE;
            else             op = OP_DELETE;
         end
      endcase
      idx = pick_index();
      if (op == OP_DECREASE && idx < heap_sb.held) key = lower_key(heap_sb.peek(idx));
      else key = pick_key();
      send_request(op, key, idx);
   endtask

   initial begin
      mix_mode_type mode;
      mix_mode_type after_mixed;
      int           in_mode;
      heap_sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty heap: every removal is rejected
      send_request(OP_EXTRACT, 0, 0);
      send_request(OP_DELETE, 0, 0);
      send_request(OP_DECREASE, -5, 0);
      send_request(OP_INSERT, KEY_MAX, 0);
      send_request(OP_INSERT, 0, 0);
      send_request(OP_INSERT, KEY_MIN, IDX_W'(IDX_MAX));
      send_request(OP_INSERT, -1, 0);
      send_request(OP_INSERT, 5, 0);
      send_request(OP_INSERT, 5, 0);
      send_request(OP_INSERT, 3, 0);
      // root is the smallest key, so raising it to KEY_MAX is rejected
      send_request(OP_DECREASE, KEY_MAX, 0);
      send_request(OP_DECREASE, heap_sb.peek(6), 6);
      send_request(OP_DECREASE, KEY_MIN, 5);
      send_request(OP_DECREASE, -7, IDX_W'(IDX_MAX));
      send_request(OP_DELETE, 0, IDX_W'(heap_sb.held - 1));
      send_request(OP_DELETE, 0, 1);
      send_request(OP_DELETE, 0, 0);
      send_request(OP_EXTRACT, 0, 0);
      send_request(OP_INSERT, -2, IDX_W'(IDX_MAX));
      send_request(OP_DELETE, 0, IDX_W'(IDX_MAX));
      while (heap_sb.held > 0) send_request(OP_EXTRACT, KEY_MAX, 0);
      send_request(OP_EXTRACT, 0, 0);

      mode        = MODE_FILL;
      after_mixed = MODE_DRAIN;
      in_mode     = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
         random_request(mode);
         case (mode)
            MODE_FILL: begin
               // stay a few requests at capacity to exercise the full case
               if (heap_sb.held == CAP) in_mode++;
               if (in_mode >= 4) begin
                  mode    = MODE_MIXED;
                  in_mode = 0;
               end
            end
            MODE_DRAIN: begin
               if (heap_sb.held == 0) in_mode++;
               if (in_mode >= 3) begin
                  mode    = MODE_MIXED;
                  in_mode = 0;
               end
            end
            default: begin
               in_mode++;
               if (in_mode >= MIXED_ITEMS) begin
                  mode        = after_mixed;
                  after_mixed = (after_mixed == MODE_DRAIN) ? MODE_FILL : MODE_DRAIN;
                  in_mode     = 0;
               end
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (heap_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (heap_sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // response side: check, then stall now and then
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) heap_sb.check_response(rsp_tuser, rsp_tdata);
         if (hold_due) begin
            // hold off long enough for the core to back up its request side
            hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && ((accepted / 32) % 3 != 1) && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
